// File: hdl/rsm_pkg.sv
// shared constants, types and opcodes for the record set membership matcher
`default_nettype none
package rsm_pkg;
	localparam int CONTACT_DEPTH = 128;
	localparam int DB_DEPTH = 4096;
	localparam int LANES = 8;
	localparam int CHUNK = 64;
	localparam int WORD_W = 64;
	localparam int REC_W = 8 * WORD_W;
	localparam int LANE_W = $clog2(LANES);
	localparam int ROWS = (CONTACT_DEPTH + LANES - 1) / LANES;
	localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int DB_AW = $clog2(DB_DEPTH);
	localparam int CC_W = 8;
	localparam int RC_W = 13;
	localparam int CH_W = 6;
	localparam int K_W = $clog2(CHUNK);

	typedef enum logic [2:0] {
		OP_LOAD_CONTACT = 3'd0,
		OP_LOAD_DB      = 3'd1,
		OP_RUN_MATCH    = 3'd2,
		OP_CLEAR_DB     = 3'd3,
		OP_CLEAR_CONTACT = 3'd4
	} op_t;

	typedef enum logic [1:0] {
		ERR_NONE       = 2'd0,
		ERR_CONTACT_FULL = 2'd1,
		ERR_DB_FULL    = 2'd2,
		ERR_BAD_OP     = 2'd3
	} err_t;

	typedef struct packed {
		logic [2:0]        opcode;
		logic [WORD_W-1:0] record_word_0;
		logic [WORD_W-1:0] record_word_1;
		logic [WORD_W-1:0] record_word_2;
		logic [WORD_W-1:0] record_word_3;
		logic [WORD_W-1:0] record_word_4;
		logic [WORD_W-1:0] record_word_5;
		logic [WORD_W-1:0] record_word_6;
		logic [WORD_W-1:0] record_word_7;
	} req_t;

	typedef struct packed {
		logic [1:0]        error_code;
		logic [CC_W-1:0]   contact_count;
		logic [RC_W-1:0]   record_count;
		logic              match_done;
		logic [CHUNK-1:0]  match_bits;
		logic [CH_W-1:0]   chunk_index;
		logic              last;
	} rsp_t;

	typedef struct packed {
		logic           valid;
		logic           last_row;
		logic           last_entry;
		logic [K_W-1:0] k;
	} merge_meta_t;

	typedef struct packed {
		logic             valid;
		logic [CHUNK-1:0] bits;
	} chunk_done_t;
endpackage
`default_nettype wire

// File: hdl/record_set_membership_matcher_core.sv
// top level: opcode decode, stores, match sequencer and result register
//
// One input channel (in_valid, in_stall, req) carries an opcode and a
// 64-byte record; one output channel (out_valid, out_stall, rsp) carries
// results. Loads, clears and bad opcodes take one item per cycle unless the
// receiver stalls, and give one registered result in the next cycle.
// A run match gives one result per group of 64 database entries. Each
// chunk walks its 64 entries, and for each entry the contact rows
// ceil(contacts/8) (at least one), with eight compare lanes checking one
// row of contacts per cycle against the entry read from the database ram.
// Each entry then passes through ram read, compare, merge and hand-off
// to the result register. No new item is taken until the last chunk
// result is out.
// Reset clears the counts of held contacts and records and the control
// state; the store contents are kept undefined until loaded.
// While the receiver stalls, the result holds, the match walk pauses at
// the next chunk, and in_stall stays high.
`default_nettype none
module record_set_membership_matcher_core import rsm_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_stall,
	input  wire req_t req,
	output logic      out_valid,
	input  wire logic out_stall,
	output rsp_t      rsp
);
	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_DRAIN
	} state_t;

	localparam int CI_W = ROW_AW + LANE_W + CC_W;

	state_t            state_q;
	logic [CC_W-1:0]   contacts_q;
	logic [RC_W-1:0]   records_q;
	logic [CH_W-1:0]   chunk_q;
	logic [CH_W-1:0]   chunk_last_q;
	logic [K_W-1:0]    k_q;
	logic [ROW_AW-1:0] row_q;
	logic [ROW_AW-1:0] row_last_q;

	logic [REC_W-1:0]  rec;
	logic              accept;
	logic              out_free;
	logic              contact_full;
	logic              db_full;
	logic              contact_we;
	logic              db_we;
	logic [REC_W-1:0]  db_rec;
	logic [DB_AW-1:0]  db_raddr;
	logic [CH_W-1:0]   chunk_last_d;
	logic [ROW_AW-1:0] row_last_d;
	logic [CC_W-1:0]   cc_less;
	logic [RC_W-1:0]   rc_less;

	// pipeline meta
	logic              v_s1;
	logic              entry_ok_s1;
	logic [ROW_AW-1:0] row_s1;
	merge_meta_t       meta_s1;
	merge_meta_t       meta_s2;
	logic [LANES-1:0]  active_s1;
	logic [LANES-1:0]  hits_s2;
	chunk_done_t       done;

	assign rec = {req.record_word_7, req.record_word_6, req.record_word_5,
		req.record_word_4, req.record_word_3, req.record_word_2,
		req.record_word_1, req.record_word_0};
	assign out_free = !out_valid || !out_stall;
	assign in_stall = !(state_q == ST_IDLE && out_free);
	assign accept = in_valid && !in_stall;
	assign contact_full = CI_W'(contacts_q) >= CI_W'(CONTACT_DEPTH);
	assign db_full = (RC_W + 1)'(records_q) >= (RC_W + 1)'(DB_DEPTH);
	assign contact_we = accept && req.opcode == OP_LOAD_CONTACT && !contact_full;
	assign db_we = accept && req.opcode == OP_LOAD_DB && !db_full;
	assign db_raddr = DB_AW'({chunk_q, k_q});
	assign cc_less = contacts_q - CC_W'(1);
	assign rc_less = records_q - RC_W'(1);
	assign chunk_last_d = (records_q == '0) ? '0 : CH_W'(rc_less >> K_W);
	assign row_last_d = (contacts_q == '0) ? '0 : ROW_AW'(cc_less >> LANE_W);

	rsm_ram #(.W(REC_W), .D(DB_DEPTH)) u_db (
		.clk  (clk),
		.we   (db_we),
		.waddr(records_q[DB_AW-1:0]),
		.wdata(rec),
		.raddr(db_raddr),
		.rdata(db_rec)
	);

	for (genvar l = 0; l < LANES; l++) begin : g_lane
		logic [ROW_AW+LANE_W-1:0] cidx;
		assign cidx = {row_s1, LANE_W'(l)};
		assign active_s1[l] = v_s1 && entry_ok_s1 &&
			(CI_W'(cidx) < CI_W'(contacts_q));
		rsm_lane u_lane (
			.clk   (clk),
			.arst_n(arst_n),
			.we    (contact_we && contacts_q[LANE_W-1:0] == LANE_W'(l)),
			.waddr (ROW_AW'(contacts_q >> LANE_W)),
			.wdata (rec),
			.raddr (row_q),
			.db_rec(db_rec),
			.active(active_s1[l]),
			.hit_s2(hits_s2[l])
		);
	end

	rsm_merge u_merge (
		.clk    (clk),
		.arst_n (arst_n),
		.hits_s2(hits_s2),
		.meta_s2(meta_s2),
		.done   (done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			entry_ok_s1 <= 1'b0;
			row_s1 <= '0;
			meta_s1 <= '0;
			meta_s2 <= '0;
		end else begin
			v_s1 <= state_q == ST_RUN;
			entry_ok_s1 <= (RC_W + 1)'({chunk_q, k_q}) < (RC_W + 1)'(records_q);
			row_s1 <= row_q;
			meta_s1.valid <= state_q == ST_RUN;
			meta_s1.last_row <= row_q == row_last_q;
			meta_s1.last_entry <= k_q == K_W'(CHUNK - 1);
			meta_s1.k <= k_q;
			meta_s2 <= meta_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			contacts_q <= '0;
			records_q <= '0;
			chunk_q <= '0;
			chunk_last_q <= '0;
			k_q <= '0;
			row_q <= '0;
			row_last_q <= '0;
			out_valid <= 1'b0;
			rsp <= '0;
		end else begin
			if (out_valid && !out_stall) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						out_valid <= 1'b1;
						rsp <= '0;
						rsp.last <= 1'b1;
						rsp.contact_count <= contacts_q;
						rsp.record_count <= records_q;
						case (req.opcode)
							OP_LOAD_CONTACT: begin
								if (contact_full) begin
									rsp.error_code <= ERR_CONTACT_FULL;
								end else begin
									contacts_q <= contacts_q + CC_W'(1);
									rsp.contact_count <= contacts_q + CC_W'(1);
								end
							end
							OP_LOAD_DB: begin
								if (db_full) begin
									rsp.error_code <= ERR_DB_FULL;
								end else begin
									records_q <= records_q + RC_W'(1);
									rsp.record_count <= records_q + RC_W'(1);
								end
							end
							OP_RUN_MATCH: begin
								// results come from the walk instead
								out_valid <= 1'b0;
								state_q <= ST_RUN;
								chunk_q <= '0;
								k_q <= '0;
								row_q <= '0;
								chunk_last_q <= chunk_last_d;
								row_last_q <= row_last_d;
							end
							OP_CLEAR_DB: begin
								records_q <= '0;
								rsp.record_count <= '0;
							end
							OP_CLEAR_CONTACT: begin
								contacts_q <= '0;
								rsp.contact_count <= '0;
							end
							default: begin
								rsp.error_code <= ERR_BAD_OP;
							end
						endcase
					end
				end
				ST_RUN: begin
					if (row_q == row_last_q) begin
						row_q <= '0;
						k_q <= k_q + K_W'(1);
						if (k_q == K_W'(CHUNK - 1)) begin
							state_q <= ST_DRAIN;
						end
					end else begin
						row_q <= row_q + ROW_AW'(1);
					end
				end
				ST_DRAIN: begin
					if (!v_s1 && !meta_s2.valid && !out_valid) begin
						if (chunk_q == chunk_last_q) begin
							state_q <= ST_IDLE;
						end else begin
							chunk_q <= chunk_q + CH_W'(1);
							state_q <= ST_RUN;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
			// the walk only starts a chunk with the result register empty
			if (done.valid) begin
				out_valid <= 1'b1;
				rsp.error_code <= ERR_NONE;
				rsp.contact_count <= contacts_q;
				rsp.record_count <= records_q;
				rsp.match_bits <= done.bits;
				rsp.chunk_index <= chunk_q;
				rsp.match_done <= chunk_q == chunk_last_q;
				rsp.last <= chunk_q == chunk_last_q;
			end
		end
	end
endmodule
`default_nettype wire

// File: hdl/rsm_ram.sv
// generic single-write, single-read ram with registered read data
`default_nettype none
module rsm_ram #(
	parameter int W = 8,
	parameter int D = 16
) (
	input  wire logic                              clk,
	input  wire logic                              we,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] waddr,
	input  wire logic [W-1:0]                      wdata,
	input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] raddr,
	output logic      [W-1:0]                      rdata
);
	logic [W-1:0] mem_q [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: hdl/rsm_lane.sv
// one compare lane: a bank of contacts and a full-record equality check
`default_nettype none
module rsm_lane import rsm_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              we,
	input  wire logic [ROW_AW-1:0] waddr,
	input  wire logic [REC_W-1:0]  wdata,
	input  wire logic [ROW_AW-1:0] raddr,
	input  wire logic [REC_W-1:0]  db_rec,
	input  wire logic              active,
	output logic                   hit_s2
);
	logic [REC_W-1:0] contact_rec;

	rsm_ram #(.W(REC_W), .D(ROWS)) u_bank (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(contact_rec)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hit_s2 <= 1'b0;
		end else begin
			hit_s2 <= active && (contact_rec == db_rec);
		end
	end
endmodule
`default_nettype wire

// File: hdl/rsm_merge.sv
// merges lane hits per database entry and builds the chunk bitmap
`default_nettype none
module rsm_merge import rsm_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic [LANES-1:0] hits_s2,
	input  wire merge_meta_t      meta_s2,
	output chunk_done_t           done
);
	logic             acc_q;
	logic [CHUNK-1:0] bits_q;
	logic             any_hit;
	logic [CHUNK-1:0] bits_next;

	always_comb begin
		any_hit = acc_q | (|hits_s2);
		bits_next = bits_q;
		if (meta_s2.valid && meta_s2.last_row) begin
			bits_next[meta_s2.k] = any_hit;
		end
		done.valid = meta_s2.valid && meta_s2.last_row && meta_s2.last_entry;
		done.bits = bits_next;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 1'b0;
			bits_q <= '0;
		end else if (meta_s2.valid) begin
			// hits of one entry collect over its contact rows
			acc_q <= meta_s2.last_row ? 1'b0 : any_hit;
			bits_q <= done.valid ? '0 : bits_next;
		end
	end
endmodule
`default_nettype wire

// File: bench/record_set_membership_matcher_core_tb.sv
// testbench for the record set membership matcher: directed and random items against a predictor
`timescale 1ns / 1ps
module record_set_membership_matcher_core_tb;
	import rsm_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	req_t req = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	rsp_t rsp;

	record_set_membership_matcher_core dut (
		.clk(clk), .arst_n(arst_n), .in_valid(in_valid), .in_stall(in_stall),
		.req(req), .out_valid(out_valid), .out_stall(out_stall), .rsp(rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	logic [REC_W-1:0] contact_mem [CONTACT_DEPTH];
	logic [REC_W-1:0] db_mem [DB_DEPTH];
	int contacts_now;
	int records_now;
	rsp_t expected_rsps [$];
	int failures = 0;
	bit idle_on = 1'b1;

	// small pool of record values so matches actually happen
	logic [REC_W-1:0] rec_pool [8];

	function automatic logic [REC_W-1:0] rec_of(req_t r);
		return {r.record_word_7, r.record_word_6, r.record_word_5, r.record_word_4,
			r.record_word_3, r.record_word_2, r.record_word_1, r.record_word_0};
	endfunction

	function automatic rsp_t plain_rsp(err_t e);
		rsp_t r;
		r = '0;
		r.error_code = e;
		r.contact_count = contacts_now[CC_W-1:0];
		r.record_count = records_now[RC_W-1:0];
		r.last = 1'b1;
		return r;
	endfunction

	task automatic predict_matcher(req_t r);
		int chunks;
		int idx;
		rsp_t e;
		logic [CHUNK-1:0] bits;
		case (r.opcode)
			OP_LOAD_CONTACT: begin
				if (contacts_now >= CONTACT_DEPTH) begin
					expected_rsps.push_back(plain_rsp(ERR_CONTACT_FULL));
				end else begin
					contact_mem[contacts_now] = rec_of(r);
					contacts_now++;
					expected_rsps.push_back(plain_rsp(ERR_NONE));
				end
			end
			OP_LOAD_DB: begin
				if (records_now >= DB_DEPTH) begin
					expected_rsps.push_back(plain_rsp(ERR_DB_FULL));
				end else begin
					db_mem[records_now] = rec_of(r);
					records_now++;
					expected_rsps.push_back(plain_rsp(ERR_NONE));
				end
			end
			OP_RUN_MATCH: begin
				chunks = (records_now + CHUNK - 1) / CHUNK;
				if (chunks == 0) chunks = 1;
				for (int ch = 0; ch < chunks; ch++) begin
					bits = '0;
					for (int k = 0; k < CHUNK; k++) begin
						idx = ch * CHUNK + k;
						if (idx < records_now)
							for (int c = 0; c < contacts_now; c++)
								if (db_mem[idx] == contact_mem[c]) bits[k] = 1'b1;
					end
					e = plain_rsp(ERR_NONE);
					e.match_bits = bits;
					e.chunk_index = ch[CH_W-1:0];
					e.match_done = (ch == chunks - 1);
					e.last = (ch == chunks - 1);
					expected_rsps.push_back(e);
				end
			end
			OP_CLEAR_DB: begin
				records_now = 0;
				expected_rsps.push_back(plain_rsp(ERR_NONE));
			end
			OP_CLEAR_CONTACT: begin
				contacts_now = 0;
				expected_rsps.push_back(plain_rsp(ERR_NONE));
			end
			default: expected_rsps.push_back(plain_rsp(ERR_BAD_OP));
		endcase
	endtask

	// valid stays high after acceptance until the next item or an idle gap replaces it
	task automatic send_item(logic [2:0] op, logic [REC_W-1:0] rec);
		req_t r;
		int gap;
		if (idle_on && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 3);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		r.opcode = op;
		{r.record_word_7, r.record_word_6, r.record_word_5, r.record_word_4,
			r.record_word_3, r.record_word_2, r.record_word_1, r.record_word_0} = rec;
		req <= r;
		in_valid <= 1'b1;
		predict_matcher(r);
		do @(posedge clk); while (in_stall);
	endtask

	function automatic logic [REC_W-1:0] rand_rec();
		logic [REC_W-1:0] v;
		for (int i = 0; i < REC_W / 32; i++) v[i*32 +: 32] = $urandom();
		return v;
	endfunction

	function automatic logic [REC_W-1:0] pool_rec();
		logic [REC_W-1:0] v;
		v = rec_pool[$urandom_range(0, 7)];
		// sometimes a near miss: one bit flipped
		if ($urandom_range(0, 5) == 0) v[$urandom_range(0, REC_W - 1)] ^= 1'b1;
		return v;
	endfunction

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (expected_rsps.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_item(OP_RUN_MATCH, '0);
		send_item(OP_LOAD_DB, '0);
		send_item(OP_LOAD_DB, '1);
		send_item(OP_RUN_MATCH, '0);
		send_item(OP_LOAD_CONTACT, '1);
		send_item(OP_LOAD_CONTACT, {8{64'h0123_4567_89ab_cdef}});
		send_item(OP_RUN_MATCH, '0);
		send_item(OP_LOAD_CONTACT, '0);
		send_item(OP_RUN_MATCH, '0);
		send_item(3'd5, '1);
		send_item(3'd6, '0);
		send_item(3'd7, rand_rec());
		send_item(OP_CLEAR_CONTACT, '0);
		send_item(OP_RUN_MATCH, '0);
		send_item(OP_CLEAR_DB, '0);
		send_item(OP_RUN_MATCH, '0);
	endtask

	task automatic test_contact_full();
		send_item(OP_CLEAR_CONTACT, '0);
		for (int i = 0; i < CONTACT_DEPTH; i++) send_item(OP_LOAD_CONTACT, rand_rec());
		send_item(OP_LOAD_CONTACT, '1);
		send_item(OP_LOAD_DB, contact_mem[CONTACT_DEPTH-1]);
		send_item(OP_RUN_MATCH, '0);
		send_item(OP_CLEAR_CONTACT, '0);
		send_item(OP_CLEAR_DB, '0);
	endtask

	task automatic test_random(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			if (i > n * 3 / 4) idle_on = 1'b0;
			pick = $urandom_range(0, 99);
			if (pick < 30) send_item(OP_LOAD_CONTACT, pool_rec());
			else if (pick < 70) send_item(OP_LOAD_DB, pool_rec());
			else if (pick < 82) send_item(OP_RUN_MATCH, rand_rec());
			else if (pick < 86) send_item(OP_CLEAR_DB, rand_rec());
			else if (pick < 90) send_item(OP_CLEAR_CONTACT, rand_rec());
			else if (pick < 95) send_item(3'($urandom_range(5, 7)), rand_rec());
			else send_item(OP_LOAD_DB, rand_rec());
		end
	endtask

	// result checker
	always @(posedge clk) begin
		rsp_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (expected_rsps.size() == 0) begin
				$error("unexpected result %p", rsp);
				failures++;
			end else begin
				e = expected_rsps.pop_front();
				if (rsp.error_code !== e.error_code) begin
					$error("error_code exp %0d got %0d", e.error_code, rsp.error_code);
					failures++;
				end
				if (rsp.contact_count !== e.contact_count) begin
					$error("contact_count exp %0d got %0d", e.contact_count, rsp.contact_count);
					failures++;
				end
				if (rsp.record_count !== e.record_count) begin
					$error("record_count exp %0d got %0d", e.record_count, rsp.record_count);
					failures++;
				end
				if (rsp.match_done !== e.match_done) begin
					$error("match_done exp %0d got %0d", e.match_done, rsp.match_done);
					failures++;
				end
				if (rsp.match_bits !== e.match_bits) begin
					$error("match_bits exp %h got %h", e.match_bits, rsp.match_bits);
					failures++;
				end
				if (rsp.chunk_index !== e.chunk_index) begin
					$error("chunk_index exp %0d got %0d", e.chunk_index, rsp.chunk_index);
					failures++;
				end
				if (rsp.last !== e.last) begin
					$error("last exp %0d got %0d", e.last, rsp.last);
					failures++;
				end
			end
		end
	end

	// receiver stall bursts
	initial begin
		int burst;
		forever begin
			@(posedge clk);
			if (idle_on && $urandom_range(0, 5) == 0) begin
				burst = $urandom_range(1, 3);
				out_stall <= 1'b1;
				repeat (burst) @(posedge clk);
			end
			out_stall <= 1'b0;
		end
	end

	initial begin
		#20_000_000;
		$display("CHECKS FAILED");
		$finish;
	end

	initial begin
		contacts_now = 0;
		records_now = 0;
		for (int i = 0; i < 8; i++) rec_pool[i] = rand_rec();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_contact_full();
		test_random(110);
		wait_drained();
		repeat (20) @(posedge clk);
		if (failures == 0 && expected_rsps.size() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end
endmodule
